// ----- rtl/core/cqpg_pkg.sv -----
// Shared types, widths and helpers for the circle quadrant point generator.
// No dependencies.
package cqpg_pkg;

    localparam int SEGMENTS_DEFAULT = 25;
    localparam int QUADRANTS        = 4;

    localparam int COORD_W  = 16;
    localparam int RADIUS_W = 15;
    localparam int STEP_W   = 5;
    localparam int INDEX_W  = 7;
    localparam int PROD_W   = RADIUS_W + STEP_W;
    localparam int RAD_W    = 32;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 2;
    localparam int BEAT_W   = 2;

    localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(QUADRANTS - 1);

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [RADIUS_W-1:0]       radius;
        logic [RADIUS_W-1:0]       t;
        logic [STEP_W-1:0]         step;
    } side_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
    } sqrt_t;

    // base +/- mag, clamped to the signed coordinate range
    function automatic logic signed [COORD_W-1:0] sat_add(
        input logic signed [COORD_W-1:0] base,
        input logic [COORD_W-1:0]        mag,
        input logic                      neg
    );
        logic [COORD_W+1:0] ext_b;
        logic [COORD_W+1:0] sum;
        logic [COORD_W-1:0] res;
        ext_b = {2'b00, mag};
        if (neg)
        begin
            ext_b = ~ext_b + 1'b1;
        end
        sum = {{2{base[COORD_W-1]}}, base} + ext_b;
        if (!sum[COORD_W+1] && (sum[COORD_W:COORD_W-1] != 2'b00))
        begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end
        else if (sum[COORD_W+1] && (sum[COORD_W:COORD_W-1] != 2'b11))
        begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            res = sum[COORD_W-1:0];
        end
        return $signed(res);
    endfunction

endpackage

// ----- rtl/core/cqpg_circle_if.sv -----
// Input channel: circle center, radius and step index with valid/ready.
// Depends on cqpg_pkg.
interface cqpg_circle_if
    import cqpg_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [RADIUS_W-1:0]       radius;
    logic [STEP_W-1:0]         step;

    modport source (output valid, output center_x, output center_y, output radius,
                    output step, input ready);
    modport sink   (input valid, input center_x, input center_y, input radius,
                    input step, output ready);
endinterface

// ----- rtl/core/cqpg_point_if.sv -----
// Output channel: one polygon vertex per beat with valid/ready.
// Depends on cqpg_pkg.
interface cqpg_point_if
    import cqpg_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [INDEX_W-1:0]        point_index;
    logic                      last;

    modport source (output valid, output point_x, output point_y, output point_index,
                    output last, input ready);
    modport sink   (input valid, input point_x, input point_y, input point_index,
                    input last, output ready);
endinterface

// ----- rtl/core/circle_quadrant_point_generator.sv -----
// Circle quadrant point generator: four polygon vertices per circle beat,
// one per quadrant, with the square root taken by a chain of ROOT_W cells.
// A circle beat is taken whenever the chain can move; each valid beat yields
// four point beats (the fourth flagged last), so the sustained rate is set by
// the single point port and its ready. A beat whose step is not below
// SEGMENTS_PER_QUADRANT yields no points. From circle beat to first point
// beat lie 3 front stages, 16 root cells and the output register.
// Depends on cqpg_pkg, the two channel interfaces, cqpg_front,
// cqpg_sqrt_cell and cqpg_emit.
module circle_quadrant_point_generator
    import cqpg_pkg::*;
#(
    parameter int SEGMENTS_PER_QUADRANT = SEGMENTS_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    cqpg_circle_if.sink   circle,
    cqpg_point_if.source  point
);

    logic  adv;
    logic  valid_c [ROOT_W+1];
    sqrt_t sqrt_c  [ROOT_W+1];
    side_t side_c  [ROOT_W+1];

    assign circle.ready = adv;

    cqpg_front #(
        .SEGMENTS_PER_QUADRANT (SEGMENTS_PER_QUADRANT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (circle.valid),
        .center_x  (circle.center_x),
        .center_y  (circle.center_y),
        .radius    (circle.radius),
        .step      (circle.step),
        .out_valid (valid_c[0]),
        .out_sqrt  (sqrt_c[0]),
        .out_side  (side_c[0])
    );

    for (genvar c = 0; c < ROOT_W; c++)
    begin : g_cell
        cqpg_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (valid_c[c]),
            .in_sqrt   (sqrt_c[c]),
            .in_side   (side_c[c]),
            .out_valid (valid_c[c+1]),
            .out_sqrt  (sqrt_c[c+1]),
            .out_side  (side_c[c+1])
        );
    end

    cqpg_emit #(
        .SEGMENTS_PER_QUADRANT (SEGMENTS_PER_QUADRANT)
    ) u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (valid_c[ROOT_W]),
        .root     (sqrt_c[ROOT_W].root),
        .in_side  (side_c[ROOT_W]),
        .adv      (adv),
        .point    (point)
    );

endmodule

// ----- rtl/core/cqpg_front.sv -----
// Front stages: r*i, division by the segment count, radicand t*(2r - t).
// Depends on cqpg_pkg.
module cqpg_front
    import cqpg_pkg::*;
#(
    parameter int SEGMENTS_PER_QUADRANT = SEGMENTS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_valid,
    input  logic signed [COORD_W-1:0] center_x,
    input  logic signed [COORD_W-1:0] center_y,
    input  logic [RADIUS_W-1:0]       radius,
    input  logic [STEP_W-1:0]         step,
    output logic                      out_valid,
    output sqrt_t                     out_sqrt,
    output side_t                     out_side
);

    // exact division by reciprocal: ceil(2^K / S), K = PROD_W + clog2(S)
    localparam int SHIFT_K = PROD_W + $clog2(SEGMENTS_PER_QUADRANT);
    localparam int MUL_W   = PROD_W + 2;
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT_K) + SEGMENTS_PER_QUADRANT - 1) / SEGMENTS_PER_QUADRANT;
    localparam logic [MUL_W-1:0] RECIP_C = MUL_W'(RECIP);

    logic                 v1_reg, v2_reg, v3_reg;
    logic                 v1_next;
    side_t                side1_reg, side2_reg, side3_reg;
    side_t                side1_next, side2_next;
    logic [PROD_W-1:0]    prod1_reg, prod1_next;
    logic [PROD_W+MUL_W-1:0] quo_full;
    logic [RADIUS_W:0]    twice_r_minus_t;
    logic [RAD_W-1:0]     rad3_reg, rad3_next;

    always_comb
    begin
        v1_next    = in_valid && ({2'b00, step} < INDEX_W'(SEGMENTS_PER_QUADRANT));
        side1_next = '{cx: center_x, cy: center_y, radius: radius, t: '0, step: step};
        prod1_next = {{STEP_W{1'b0}}, radius} * {{RADIUS_W{1'b0}}, step};

        quo_full   = {{MUL_W{1'b0}}, prod1_reg} * {{PROD_W{1'b0}}, RECIP_C};
        side2_next = side1_reg;
        side2_next.t = quo_full[SHIFT_K +: RADIUS_W];

        twice_r_minus_t = {side2_reg.radius, 1'b0} - {1'b0, side2_reg.t};
        rad3_next = {{(RAD_W-RADIUS_W){1'b0}}, side2_reg.t}
                  * {{(RAD_W-RADIUS_W-1){1'b0}}, twice_r_minus_t};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= v1_next;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side1_reg <= side1_next;
            prod1_reg <= prod1_next;
            side2_reg <= side2_next;
            side3_reg <= side2_reg;
            rad3_reg  <= rad3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_side  = side3_reg;
    assign out_sqrt  = '{rad: rad3_reg, root: '0, rem: '0};

endmodule

// ----- rtl/core/cqpg_sqrt_cell.sv -----
// One cell of the square root chain: settles one root bit per cell.
// Depends on cqpg_pkg.
module cqpg_sqrt_cell
    import cqpg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  logic  in_valid,
    input  sqrt_t in_sqrt,
    input  side_t in_side,
    output logic  out_valid,
    output sqrt_t out_sqrt,
    output side_t out_side
);

    logic         valid_reg;
    sqrt_t        sqrt_reg, sqrt_next;
    side_t        side_reg;
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;

    always_comb
    begin
        rem_sh = {in_sqrt.rem, in_sqrt.rad[RAD_W-1 -: 2]};
        trial  = {2'b00, in_sqrt.root, 2'b01};
        sqrt_next.rad = {in_sqrt.rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            sqrt_next.rem  = REM_W'(rem_sh - trial);
            sqrt_next.root = {in_sqrt.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            sqrt_next.rem  = REM_W'(rem_sh);
            sqrt_next.root = {in_sqrt.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqrt_reg <= sqrt_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_sqrt  = sqrt_reg;
    assign out_side  = side_reg;

endmodule

// ----- rtl/core/cqpg_emit.sv -----
// Vertex forming with saturation and the four-beat output register.
// Depends on cqpg_pkg and cqpg_point_if.
module cqpg_emit
    import cqpg_pkg::*;
#(
    parameter int SEGMENTS_PER_QUADRANT = SEGMENTS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [ROOT_W-1:0]   root,
    input  side_t               in_side,
    output logic                adv,
    cqpg_point_if.source        point
);

    logic                      busy_reg;
    logic [BEAT_W-1:0]         cnt_reg;
    logic signed [COORD_W-1:0] x_reg [QUADRANTS];
    logic signed [COORD_W-1:0] y_reg [QUADRANTS];
    logic [INDEX_W-1:0]        idx_reg [QUADRANTS];
    logic signed [COORD_W-1:0] x_next [QUADRANTS];
    logic signed [COORD_W-1:0] y_next [QUADRANTS];
    logic [INDEX_W-1:0]        idx_next [QUADRANTS];
    logic [COORD_W-1:0]        u_ext;
    logic                      load;

    always_comb
    begin
        u_ext = {1'b0, in_side.radius - in_side.t};
        x_next[0] = sat_add(in_side.cx, u_ext, 1'b1);
        y_next[0] = sat_add(in_side.cy, root,  1'b1);
        x_next[1] = sat_add(in_side.cx, root,  1'b0);
        y_next[1] = sat_add(in_side.cy, u_ext, 1'b1);
        x_next[2] = sat_add(in_side.cx, u_ext, 1'b0);
        y_next[2] = sat_add(in_side.cy, root,  1'b0);
        x_next[3] = sat_add(in_side.cx, root,  1'b1);
        y_next[3] = sat_add(in_side.cy, u_ext, 1'b0);
        for (int q = 0; q < QUADRANTS; q++)
        begin
            idx_next[q] = INDEX_W'(int'(in_side.step) + q * SEGMENTS_PER_QUADRANT);
        end
    end

    assign load = !busy_reg || (point.ready && (cnt_reg == LAST_BEAT));
    assign adv  = !in_valid || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= in_valid;
            cnt_reg  <= '0;
        end
        else if (point.ready)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            idx_reg <= idx_next;
        end
    end

    assign point.valid       = busy_reg;
    assign point.point_x     = x_reg[cnt_reg];
    assign point.point_y     = y_reg[cnt_reg];
    assign point.point_index = idx_reg[cnt_reg];
    assign point.last        = (cnt_reg == LAST_BEAT);

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench for circle_quadrant_point_generator: directed and random circle beats in,
// every vertex beat checked against an in-bench prediction of the four points.
// Depends on cqpg_pkg, cqpg_circle_if, cqpg_point_if and the block itself.
module testbench
    import cqpg_pkg::*;
;

    localparam int SEGS           = SEGMENTS_DEFAULT;
    localparam int RANDOM_ITEMS   = 92;
    localparam int QUIET_TAIL     = 20;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [RADIUS_W-1:0]       radius;
        logic [STEP_W-1:0]         step;
    } circle_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [INDEX_W-1:0]        index;
        logic                      last;
    } vertex_t;

    logic clk;
    logic rst_n;

    circle_t pending_q [$];
    vertex_t expect_q  [$];

    int in_gap_reg;
    int out_gap_reg;
    int err_cnt   = 0;
    int stall_cnt = 0;
    int drain_cnt = 0;

    cqpg_circle_if circle_bus ();
    cqpg_point_if  point_bus ();

    circle_quadrant_point_generator #(
        .SEGMENTS_PER_QUADRANT (SEGS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .circle (circle_bus),
        .point  (point_bus)
    );

    function automatic longint unsigned isqrt(input longint unsigned n);
        longint unsigned num;
        longint unsigned res;
        longint unsigned probe;
        num   = n;
        res   = 0;
        probe = 64'd1 << 62;
        while (probe > num)
        begin
            probe = probe >> 2;
        end
        while (probe != 0)
        begin
            if (num >= res + probe)
            begin
                num = num - (res + probe);
                res = (res >> 1) + probe;
            end
            else
            begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat16(input longint v);
        longint c;
        c = v;
        if (c > 32767)
        begin
            c = 32767;
        end
        if (c < -32768)
        begin
            c = -32768;
        end
        return COORD_W'(c);
    endfunction

    function automatic void predict(input circle_t c);
        longint  cx;
        longint  cy;
        longint  r;
        longint  i;
        longint  t;
        longint  u;
        longint  d;
        longint  px [QUADRANTS];
        longint  py [QUADRANTS];
        vertex_t v;
        cx = longint'($signed(c.cx));
        cy = longint'($signed(c.cy));
        r  = longint'(c.radius);
        i  = longint'(c.step);
        if (i >= SEGS)
        begin
            return;
        end
        t = (r * i) / SEGS;
        u = r - t;
        d = longint'(isqrt(longint'(r * r - u * u)));
        px[0] = cx - u;  py[0] = cy - d;
        px[1] = cx + d;  py[1] = cy - u;
        px[2] = cx + u;  py[2] = cy + d;
        px[3] = cx - d;  py[3] = cy + u;
        for (int q = 0; q < QUADRANTS; q++)
        begin
            v.x     = sat16(px[q]);
            v.y     = sat16(py[q]);
            v.index = INDEX_W'(i + q * SEGS);
            v.last  = (q == QUADRANTS - 1);
            expect_q.push_back(v);
        end
    endfunction

    task automatic add_item(
        input logic signed [COORD_W-1:0] cx,
        input logic signed [COORD_W-1:0] cy,
        input logic [RADIUS_W-1:0]       r,
        input logic [STEP_W-1:0]         s
    );
        circle_t c;
        c.cx     = cx;
        c.cy     = cy;
        c.radius = r;
        c.step   = s;
        pending_q.push_back(c);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        add_item(16'sd0, 16'sd0, 15'd0, 5'd0);
        add_item(16'sd100, -16'sd200, 15'd0, 5'd13);
        add_item(16'sh7fff, 16'sh8000, 15'h7fff, 5'd0);
        add_item(16'sh8000, 16'sh7fff, 15'h7fff, 5'd12);
        add_item(16'sd0, 16'sd0, 15'h7fff, 5'd24);
        add_item(16'sd320, 16'sd480, 15'd160, 5'd25);
        add_item(16'sd320, 16'sd480, 15'd160, 5'd31);
        add_item(-16'sd1600, 16'sd800, 15'd400, 5'd7);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            add_item(COORD_W'($urandom), COORD_W'($urandom),
                     (n % 8 == 0) ? {RADIUS_W{1'b1}} : RADIUS_W'($urandom),
                     (n % 10 == 9) ? STEP_W'($urandom_range(SEGS, (1 << STEP_W) - 1))
                                   : STEP_W'($urandom_range(0, SEGS - 1)));
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // circle driver: holds a beat until accepted, idles in bursts until the tail
    always @(posedge clk or negedge rst_n)
    begin : driver
        circle_t item;
        if (!rst_n)
        begin
            circle_bus.valid    <= 1'b0;
            circle_bus.center_x <= '0;
            circle_bus.center_y <= '0;
            circle_bus.radius   <= '0;
            circle_bus.step     <= '0;
            in_gap_reg          <= 0;
        end
        else if (!circle_bus.valid || circle_bus.ready)
        begin
            if (pending_q.size() == 0)
            begin
                circle_bus.valid <= 1'b0;
            end
            else if (pending_q.size() >= QUIET_TAIL && in_gap_reg > 0)
            begin
                circle_bus.valid <= 1'b0;
                in_gap_reg       <= in_gap_reg - 1;
            end
            else if (pending_q.size() >= QUIET_TAIL && $urandom_range(0, 3) == 0)
            begin
                circle_bus.valid <= 1'b0;
                in_gap_reg       <= int'($urandom_range(0, 17));
            end
            else
            begin
                item = pending_q.pop_front();
                circle_bus.valid    <= 1'b1;
                circle_bus.center_x <= item.cx;
                circle_bus.center_y <= item.cy;
                circle_bus.radius   <= item.radius;
                circle_bus.step     <= item.step;
                in_gap_reg          <= 0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_bus.ready <= 1'b0;
            out_gap_reg     <= 0;
        end
        else if (pending_q.size() < QUIET_TAIL)
        begin
            point_bus.ready <= 1'b1;
            out_gap_reg     <= 0;
        end
        else if (out_gap_reg > 0)
        begin
            point_bus.ready <= 1'b0;
            out_gap_reg     <= out_gap_reg - 1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            point_bus.ready <= 1'b0;
            out_gap_reg     <= int'($urandom_range(0, 17));
        end
        else
        begin
            point_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : monitor
        vertex_t exp_v;
        circle_t seen;
        if (rst_n)
        begin
            if (point_bus.valid && point_bus.ready)
            begin
                if (expect_q.size() == 0)
                begin
                    $error("unexpected point beat: point_index %0d", point_bus.point_index);
                    err_cnt = err_cnt + 1;
                end
                else
                begin
                    exp_v = expect_q.pop_front();
                    if (point_bus.point_x !== exp_v.x)
                    begin
                        $error("point_x: expected %0d, actual %0d", exp_v.x, point_bus.point_x);
                        err_cnt = err_cnt + 1;
                    end
                    if (point_bus.point_y !== exp_v.y)
                    begin
                        $error("point_y: expected %0d, actual %0d", exp_v.y, point_bus.point_y);
                        err_cnt = err_cnt + 1;
                    end
                    if (point_bus.point_index !== exp_v.index)
                    begin
                        $error("point_index: expected %0d, actual %0d",
                               exp_v.index, point_bus.point_index);
                        err_cnt = err_cnt + 1;
                    end
                    if (point_bus.last !== exp_v.last)
                    begin
                        $error("last: expected %0d, actual %0d", exp_v.last, point_bus.last);
                        err_cnt = err_cnt + 1;
                    end
                end
            end
            if (circle_bus.valid && circle_bus.ready)
            begin
                seen.cx     = circle_bus.center_x;
                seen.cy     = circle_bus.center_y;
                seen.radius = circle_bus.radius;
                seen.step   = circle_bus.step;
                predict(seen);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pending_q.size() == 0 && !circle_bus.valid && expect_q.size() == 0)
        begin
            drain_cnt = drain_cnt + 1;
            if (drain_cnt >= DRAIN_CYCLES)
            begin
                if (err_cnt == 0)
                begin
                    $display("Testbench completed without errors");
                end
                else
                begin
                    $display("Testbench completed WITH ERRORS");
                end
                $finish;
            end
        end
        else
        begin
            drain_cnt = 0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_cnt = 0;
        end
        else if ((circle_bus.valid && circle_bus.ready) || (point_bus.valid && point_bus.ready))
        begin
            stall_cnt = 0;
        end
        else
        begin
            stall_cnt = stall_cnt + 1;
            if (stall_cnt >= WATCHDOG_LIMIT)
            begin
                $error("watchdog: no beat accepted for %0d cycles", stall_cnt);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule
